### rtl/core/rcct_pkg.sv
// Shared types and constants for the row/column coverage tree.
package rcct_pkg;

    localparam int MAX_SIDE = 1024;
    localparam int LEAF_W = $clog2(MAX_SIDE);
    localparam int COORD_W = 11;
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_PLACE  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LEAF,
        ST_WALK,
        ST_QUERY,
        ST_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic clear_step;
        logic leaf_step;
        logic walk_step;
        logic query_step;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic walk_done;
        logic query_done;
        logic is_query;
        logic is_update;
    } dp_status_t;

endpackage

### rtl/core/row_column_coverage_tree.sv
// Top level of the row/column coverage tree block.
//
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             opcode, row_a, col_a, row_b, col_b
// result    out        done strobe, one cycle    covered
// config    in         cfg_valid & cfg_ready     cfg_data (board size)
//
// After reset the block clears the count and flag memories, one leaf a
// cycle, and holds busy high while it does so; configuration writes are
// taken throughout. Every tree level takes a flag read and then a combine.
// A place or remove keeps busy high after it is accepted for one leaf
// update, then ten levels in both trees side by side and a check that sees
// the walk end. A query keeps busy high for up to eleven levels, an end
// check and a step that forms the answer; its result shows on covered with
// done high in the next cycle. The receiver cannot stall.
module row_column_coverage_tree
    import rcct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [COORD_W-1:0] row_a,
    input  logic [COORD_W-1:0] col_a,
    input  logic [COORD_W-1:0] row_b,
    input  logic [COORD_W-1:0] col_b,
    output logic               done,
    output logic               covered,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COORD_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The single register is always writable.
    assign cfg_ready = 1'b1;

    rcct_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .status(status),
        .cmd(cmd), .busy(busy), .done(done)
    );

    rcct_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .opcode(opcode),
        .row_a(row_a), .col_a(col_a), .row_b(row_b), .col_b(col_b),
        .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
        .status(status), .covered(covered)
    );

endmodule

### rtl/core/rcct_tree.sv
// One coverage tree: counts, node flags, update walk and range query.
module rcct_tree
    import rcct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear_en,
    input  logic [LEAF_W-1:0]  clear_addr,
    input  logic               load,
    input  logic               upd_en,
    input  logic               add,
    input  logic [LEAF_W-1:0]  leaf_in,
    input  logic               leaf_step,
    input  logic               walk_step,
    input  logic               query_en,
    input  logic [LEAF_W+1:0]  lo_in,
    input  logic [LEAF_W+1:0]  hi_in,
    input  logic               query_step,
    output logic               walk_done,
    output logic               query_done,
    output logic               all_ok
);

    // Node 1 is the root, the children of node n are 2n and 2n+1, and leaf i
    // is node MAX_SIDE + i. Leaf flags (count nonzero) and internal flags sit
    // in two flag memories with registered reads, so each tree level of a
    // walk or a query has a read step and then a combine step.
    logic [COUNT_W-1:0] count_mem [MAX_SIDE];
    logic               nz_mem [MAX_SIDE];
    logic               flag_mem [MAX_SIDE];

    logic [COUNT_W-1:0] cnt_rd_reg;
    logic               nz_a_reg;
    logic               nz_b_reg;
    logic               fl_a_reg;
    logic               fl_b_reg;
    logic               leaf_a_reg;
    logic               leaf_b_reg;

    logic [LEAF_W-1:0]  leaf_reg;
    logic               add_reg;
    logic               en_reg;
    logic               qen_reg;
    logic               phase_reg;
    logic [LEAF_W:0]    node_reg;
    logic               cur_reg;
    logic [LEAF_W+1:0]  lo_reg;
    logic [LEAF_W+1:0]  hi_reg;
    logic               all_reg;

    logic [LEAF_W:0]    addr_a;
    logic [LEAF_W:0]    addr_b;
    logic               flag_a;
    logic               flag_b;
    logic [LEAF_W:0]    parent;
    logic               parent_flag;
    logic [COUNT_W-1:0] cnt_new;
    logic               all_new;

    always_comb
    begin
        // Port A reads the sibling on a walk and the left edge of a query;
        // port B reads the right edge of a query.
        if (qen_reg)
            addr_a = lo_reg[LEAF_W:0];
        else
            addr_a = node_reg ^ (LEAF_W+1)'(1);
        addr_b = (LEAF_W+1)'(hi_reg - 1'b1);
        flag_a = leaf_a_reg ? nz_a_reg : fl_a_reg;
        flag_b = leaf_b_reg ? nz_b_reg : fl_b_reg;
        parent = node_reg >> 1;
        parent_flag = cur_reg & flag_a;
        cnt_new = cnt_rd_reg;
        if (add_reg && cnt_rd_reg != COUNT_MAX)
            cnt_new = cnt_rd_reg + 1'b1;
        else if (!add_reg && cnt_rd_reg != '0)
            cnt_new = cnt_rd_reg - 1'b1;
        all_new = all_reg;
        if (lo_reg[0])
            all_new = all_new & flag_a;
        if (hi_reg[0])
            all_new = all_new & flag_b;
    end

    assign walk_done  = (node_reg == (LEAF_W+1)'(1));
    assign query_done = !qen_reg || !(lo_reg < hi_reg);
    assign all_ok     = all_reg;

    always_ff @(posedge clk)
    begin
        if (clear_en)
        begin
            count_mem[clear_addr] <= '0;
            nz_mem[clear_addr] <= 1'b0;
            flag_mem[clear_addr] <= 1'b0;
        end
        else
        begin
            if (en_reg && leaf_step)
            begin
                count_mem[leaf_reg] <= cnt_new;
                nz_mem[leaf_reg] <= (cnt_new != '0);
            end
            if (en_reg && walk_step && phase_reg && !walk_done)
                flag_mem[parent[LEAF_W-1:0]] <= parent_flag;
        end
        if (load)
            cnt_rd_reg <= count_mem[leaf_in];
        nz_a_reg <= nz_mem[addr_a[LEAF_W-1:0]];
        fl_a_reg <= flag_mem[addr_a[LEAF_W-1:0]];
        nz_b_reg <= nz_mem[addr_b[LEAF_W-1:0]];
        fl_b_reg <= flag_mem[addr_b[LEAF_W-1:0]];
        leaf_a_reg <= addr_a[LEAF_W];
        leaf_b_reg <= addr_b[LEAF_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
            qen_reg <= 1'b0;
            phase_reg <= 1'b0;
            node_reg <= (LEAF_W+1)'(1);
            cur_reg <= 1'b0;
            all_reg <= 1'b1;
            leaf_reg <= '0;
            add_reg <= 1'b0;
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                en_reg <= upd_en;
                qen_reg <= query_en;
                leaf_reg <= leaf_in;
                add_reg <= add;
                node_reg <= {1'b1, leaf_in};
                lo_reg <= lo_in;
                hi_reg <= hi_in;
                all_reg <= 1'b1;
                phase_reg <= 1'b0;
            end
            if (leaf_step)
                cur_reg <= (cnt_new != '0);
            if (walk_step && !walk_done)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    cur_reg <= parent_flag;
                    node_reg <= parent;
                end
            end
            if (query_step && !query_done)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    all_reg <= all_new;
                    lo_reg <= (lo_reg + (LEAF_W+2)'(lo_reg[0])) >> 1;
                    hi_reg <= (hi_reg - (LEAF_W+2)'(hi_reg[0])) >> 1;
                end
            end
        end
    end

endmodule

### rtl/core/rcct_datapath.sv
// Datapath: input decode, board size register and the two trees.
module rcct_datapath
    import rcct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [1:0]         opcode,
    input  logic [COORD_W-1:0] row_a,
    input  logic [COORD_W-1:0] col_a,
    input  logic [COORD_W-1:0] row_b,
    input  logic [COORD_W-1:0] col_b,
    input  logic               cfg_we,
    input  logic [COORD_W-1:0] cfg_data,
    output dp_status_t         status,
    output logic               covered
);

    logic [COORD_W-1:0] size_reg;
    logic [LEAF_W:0]    clr_reg;
    logic               covered_reg;
    logic [COORD_W-1:0] side;
    logic               is_upd;
    logic               is_qry;
    logic               add;
    logic               row_in;
    logic               col_in;
    logic [COORD_W-1:0] r_first;
    logic [COORD_W-1:0] r_last;
    logic [COORD_W-1:0] c_first;
    logic [COORD_W-1:0] c_last;
    logic               r_ok;
    logic               c_ok;
    logic               r_done;
    logic               c_done;
    logic               r_q;
    logic               c_q;
    logic               r_all;
    logic               c_all;
    logic               r_empty_reg;
    logic               c_empty_reg;

    always_comb
    begin
        side = size_reg;
        if (side == '0)
            side = COORD_W'(1);
        if (side > COORD_W'(MAX_SIDE))
            side = COORD_W'(MAX_SIDE);
        is_upd = (opcode == OP_PLACE) || (opcode == OP_REMOVE);
        is_qry = (opcode == OP_QUERY);
        add = (opcode == OP_PLACE);
        row_in = (row_a != '0) && (row_a <= side);
        col_in = (col_a != '0) && (col_a <= side);
        r_first = (row_a == '0) ? COORD_W'(1) : row_a;
        r_last = (row_b > side) ? side : row_b;
        c_first = (col_a == '0) ? COORD_W'(1) : col_a;
        c_last = (col_b > side) ? side : col_b;
        r_ok = is_qry && (r_first <= r_last);
        c_ok = is_qry && (c_first <= c_last);
    end

    rcct_tree u_row (
        .clk(clk), .rst_n(rst_n),
        .clear_en(cmd.clear_step), .clear_addr(clr_reg[LEAF_W-1:0]),
        .load(cmd.load), .upd_en(is_upd && row_in), .add(add),
        .leaf_in(LEAF_W'(row_a - 1'b1)),
        .leaf_step(cmd.leaf_step), .walk_step(cmd.walk_step),
        .query_en(r_ok),
        .lo_in((LEAF_W+2)'(r_first) - 1'b1 + (LEAF_W+2)'(MAX_SIDE)),
        .hi_in((LEAF_W+2)'(r_last) + (LEAF_W+2)'(MAX_SIDE)),
        .query_step(cmd.query_step),
        .walk_done(r_done), .query_done(r_q), .all_ok(r_all)
    );

    rcct_tree u_col (
        .clk(clk), .rst_n(rst_n),
        .clear_en(cmd.clear_step), .clear_addr(clr_reg[LEAF_W-1:0]),
        .load(cmd.load), .upd_en(is_upd && col_in), .add(add),
        .leaf_in(LEAF_W'(col_a - 1'b1)),
        .leaf_step(cmd.leaf_step), .walk_step(cmd.walk_step),
        .query_en(c_ok),
        .lo_in((LEAF_W+2)'(c_first) - 1'b1 + (LEAF_W+2)'(MAX_SIDE)),
        .hi_in((LEAF_W+2)'(c_last) + (LEAF_W+2)'(MAX_SIDE)),
        .query_step(cmd.query_step),
        .walk_done(c_done), .query_done(c_q), .all_ok(c_all)
    );

    assign status.clear_done = clr_reg[LEAF_W];
    assign status.walk_done  = r_done && c_done;
    assign status.query_done = r_q && c_q;
    assign status.is_query   = is_qry;
    assign status.is_update  = is_upd;
    assign covered = covered_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= COORD_W'(MAX_SIDE);
            clr_reg <= '0;
            covered_reg <= 1'b0;
            r_empty_reg <= 1'b0;
            c_empty_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                size_reg <= cfg_data;
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.load)
            begin
                r_empty_reg <= !r_ok;
                c_empty_reg <= !c_ok;
            end
            if (cmd.finish)
                covered_reg <= r_empty_reg || c_empty_reg || r_all || c_all;
        end
    end

endmodule

### rtl/core/rcct_ctrl.sv
// Controller state machine sequencing clear, update and query.
module rcct_ctrl
    import rcct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        done_next = 1'b0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                    state_next = ST_IDLE;
                else
                    cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.is_update)
                        state_next = ST_LEAF;
                    else if (status.is_query)
                        state_next = ST_QUERY;
                end
            end
            ST_LEAF:
            begin
                cmd.leaf_step = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                    state_next = ST_IDLE;
            end
            ST_QUERY:
            begin
                cmd.query_step = 1'b1;
                if (status.query_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign done = done_reg;

endmodule
